### rtl/core/dvtg_pkg.sv
// Package of shared types, constants and the sine table function of the tone generator.
`timescale 1ns / 1ps
`default_nettype none
package dvtg_pkg;

	// Default sizes of the phase accumulators, cycle counters and sine table.
	localparam int unsigned PHASE_BITS_DEF      = 24;
	localparam int unsigned COUNT_BITS_DEF      = 24;
	localparam int unsigned SINE_TABLE_BITS_DEF = 10;

	// Fixed widths of the channel fields.
	localparam int unsigned STEP_W   = 24;
	localparam int unsigned WCOUNT_W = 24;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned AMP_W    = 16;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned WAVE_W   = 17;
	localparam int unsigned SINE_W   = 16;
	localparam int unsigned NUM_VOICES = 2;

	typedef enum logic [1:0] {
		WAVE_SQUARE   = 2'd0,
		WAVE_SINE     = 2'd1,
		WAVE_SAW      = 2'd2,
		WAVE_TRIANGLE = 2'd3
	} wave_t;

	typedef enum logic {
		REG_WAVEFORM  = 1'b0,
		REG_AMPLITUDE = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		CMD_TICK    = 1'b0,
		CMD_REQUEST = 1'b1
	} cmd_t;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned Q30_ONE     = 64'd1 << 30;

	// Magnitude of sin for q / 2^(table_bits-2) quarter cycles, in Q15.
	// An 11th order Taylor series in Q30, evaluated once per table entry
	// while the design is elaborated.
	function automatic logic [SINE_W-1:0] sine_mag(input int unsigned q,
			input int unsigned table_bits);
		longint unsigned th;
		longint unsigned t;
		longint unsigned f;
		longint unsigned s;
		th = 64'(q);
		th = (th * HALF_PI_Q30) >> (table_bits - 2);
		t  = (th * th) >> 30;
		f  = Q30_ONE - t / 110;
		f  = Q30_ONE - ((t * f) >> 30) / 72;
		f  = Q30_ONE - ((t * f) >> 30) / 42;
		f  = Q30_ONE - ((t * f) >> 30) / 20;
		f  = Q30_ONE - ((t * f) >> 30) / 6;
		s  = (th * f) >> 30;
		return SINE_W'((s + 64'd16384) >> 15);
	endfunction

endpackage
`default_nettype wire

### rtl/core/dvtg_if.sv
// Valid/ready channel interfaces for tone commands and mixed samples.
`timescale 1ns / 1ps
`default_nettype none
interface dvtg_in_if import dvtg_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                cmd;
	logic [STEP_W-1:0]   phase_step;
	logic [WCOUNT_W-1:0] tone_cycles;

	modport source (output valid, output cmd, output phase_step, output tone_cycles,
		input ready);
	modport sink (input valid, input cmd, input phase_step, input tone_cycles,
		output ready);
endinterface

interface dvtg_out_if import dvtg_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       voice_one_busy;
	logic                       voice_two_busy;

	modport source (output valid, output sample, output voice_one_busy,
		output voice_two_busy, input ready);
	modport sink (input valid, input sample, input voice_one_busy,
		input voice_two_busy, output ready);
endinterface
`default_nettype wire

### rtl/core/dual_voice_tone_generator.sv
// Top level of the two-voice tone generator: voice state, wave pipeline and mixer.
`timescale 1ns / 1ps
`default_nettype none

// Two-voice tone generator. Each transaction on the tone channel is either a
// sample tick or a tone request. A request (phase step, cycle count) goes to
// voice one and voice two in turn and waits in that voice's pending slot; it
// yields no sample. While a voice still plays, an untaken pending slot cuts
// it short at its next phase wrap, and the slot is loaded as soon as the
// voice has no cycles left. A tick advances the phase accumulator of each
// playing voice, counts its cycles down on every wrap and yields one sample
// transaction: the sum of amplitude/2 times the selected wave of each playing
// voice, saturated to signed Q1.15, with the busy flag of each voice after
// the tick. The block takes one transaction every clock cycle unless a
// stalled output has filled the pipeline. Voice state is updated in the
// cycle a transaction is taken, so back-to-back ticks never wait on each
// other; the wave shape, sine lookup, amplitude multiply and mix follow in
// three pipeline stages and an output register. The accumulator and counter
// update of each voice, done in the cycle a tick is taken, sets that rate.
// The sine comes from a quarter-wave table of 2^(SINE_TABLE_BITS-2)+1 entries
// built at elaboration. The waveform and amplitude registers are meant to be
// written while no tick is in flight.
module dual_voice_tone_generator import dvtg_pkg::*; #(
	parameter int unsigned PHASE_BITS      = PHASE_BITS_DEF,
	parameter int unsigned COUNT_BITS      = COUNT_BITS_DEF,
	parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              wr_en,
	input  wire              wr_index,
	input  wire  [CFG_W-1:0] wr_data,
	dvtg_in_if.sink          tone,
	dvtg_out_if.source       mix
);

	localparam int unsigned QW         = SINE_TABLE_BITS - 2;
	localparam int unsigned AW         = SINE_TABLE_BITS - 1;
	localparam int unsigned SINE_DEPTH = (1 << QW) + 1;
	localparam int unsigned PROD_W     = 2 * WAVE_W;
	localparam int unsigned MIX_W      = WAVE_W + 1;

	// Configuration registers.
	wave_t            waveform_q;
	logic [AMP_W-1:0] amplitude_q;

	// Voice state.
	logic [PHASE_BITS-1:0] phase_q  [NUM_VOICES];
	logic [PHASE_BITS-1:0] step_q   [NUM_VOICES];
	logic [COUNT_BITS-1:0] left_q   [NUM_VOICES];
	logic [PHASE_BITS-1:0] pstep_q  [NUM_VOICES];
	logic [COUNT_BITS-1:0] pcount_q [NUM_VOICES];
	logic                  taken_q  [NUM_VOICES];
	logic                  last_went_second_q;

	// Next voice state for a tick.
	logic [PHASE_BITS-1:0] phase_d  [NUM_VOICES];
	logic [PHASE_BITS-1:0] step_d   [NUM_VOICES];
	logic [COUNT_BITS-1:0] left_d   [NUM_VOICES];
	logic                  taken_d  [NUM_VOICES];
	logic                  active_d [NUM_VOICES];

	// Pipeline.
	logic                  valid_s1, valid_s2, valid_s3, out_valid_q;
	logic                  en_s1, en_s2, en_s3, en_out;
	logic [PHASE_BITS-1:0] phase_s1  [NUM_VOICES];
	logic                  active_s1 [NUM_VOICES];
	logic                  busy_s1   [NUM_VOICES];
	logic [SINE_W-1:0]     mag_s2    [NUM_VOICES];
	logic                  neg_s2    [NUM_VOICES];
	logic [WAVE_W-1:0]     other_s2  [NUM_VOICES];
	logic                  active_s2 [NUM_VOICES];
	logic                  busy_s2   [NUM_VOICES];
	logic signed [PROD_W-1:0] prod_s3 [NUM_VOICES];
	logic                  busy_s3   [NUM_VOICES];
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                  busy_q    [NUM_VOICES];

	// Stage-one wave shaping.
	logic [AW-1:0]     rom_addr [NUM_VOICES];
	logic              neg_s1c  [NUM_VOICES];
	logic [WAVE_W-1:0] other_c  [NUM_VOICES];

	logic signed [PROD_W-1:0]   prod_c [NUM_VOICES];
	logic signed [SAMPLE_W-1:0] sample_c;

	logic                  tick_acc, req_acc;
	logic [PHASE_BITS-1:0] req_step;
	logic [COUNT_BITS-1:0] req_count;
	logic [55:0]           step_wide;
	logic [31:0]           count_wide;

	// Quarter-wave sine table, constant.
	logic [SINE_W-1:0] sine_rom [SINE_DEPTH];

	for (genvar gi = 0; gi < SINE_DEPTH; gi++) begin : g_rom
		assign sine_rom[gi] = sine_mag(gi, SINE_TABLE_BITS);
	end

	// Every stage moves on when it is empty or its successor moves on, so a
	// sample waiting at the output does not stop new transactions as long as
	// a bubble remains in the pipeline.
	assign en_out     = !out_valid_q || mix.ready;
	assign en_s3      = !valid_s3 || en_out;
	assign en_s2      = !valid_s2 || en_s3;
	assign en_s1      = !valid_s1 || en_s2;
	assign tone.ready = en_s1;

	assign tick_acc = tone.valid && en_s1 && (tone.cmd == CMD_TICK);
	assign req_acc  = tone.valid && en_s1 && (tone.cmd == CMD_REQUEST);

	// The Q0.24 step lines up with the top of the accumulator: padded with
	// zeros below when the accumulator is wider, truncated when narrower.
	assign step_wide  = {tone.phase_step, 32'd0};
	assign req_step   = step_wide[55 -: PHASE_BITS];
	assign count_wide = 32'(tone.tone_cycles);
	assign req_count  = count_wide[COUNT_BITS-1:0];

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q  <= WAVE_SQUARE;
			amplitude_q <= '0;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_WAVEFORM:  waveform_q  <= wave_t'(wr_data[1:0]);
				REG_AMPLITUDE: amplitude_q <= wr_data[AMP_W-1:0];
				default:       waveform_q  <= waveform_q;
			endcase
		end
	end

	// Voice update on a tick: advance the phase of a playing voice, count a
	// cycle down on a wrap, cut the voice to its last cycle when a request
	// is pending, and load the pending slot once the voice has run out.
	always_comb begin
		logic [PHASE_BITS:0]   sum;
		logic [COUNT_BITS-1:0] left_a;
		for (int v = 0; v < NUM_VOICES; v++) begin
			active_d[v] = (left_q[v] != '0);
			sum         = {1'b0, phase_q[v]} + {1'b0, step_q[v]};
			phase_d[v]  = active_d[v] ? sum[PHASE_BITS-1:0] : phase_q[v];
			left_a      = left_q[v];
			if (active_d[v] && sum[PHASE_BITS]) begin
				left_a = left_q[v] - COUNT_BITS'(1);
				if (!taken_q[v] && left_a > COUNT_BITS'(1)) begin
					left_a = COUNT_BITS'(1);
				end
			end
			step_d[v]  = step_q[v];
			left_d[v]  = left_a;
			taken_d[v] = taken_q[v];
			if (!taken_q[v] && left_a == '0) begin
				step_d[v]  = pstep_q[v];
				left_d[v]  = pcount_q[v];
				taken_d[v] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < NUM_VOICES; v++) begin
				phase_q[v]  <= '0;
				step_q[v]   <= '0;
				left_q[v]   <= '0;
				pstep_q[v]  <= '0;
				pcount_q[v] <= '0;
				taken_q[v]  <= 1'b0;
			end
			last_went_second_q <= 1'b1;
		end else if (tick_acc) begin
			for (int v = 0; v < NUM_VOICES; v++) begin
				phase_q[v] <= phase_d[v];
				step_q[v]  <= step_d[v];
				left_q[v]  <= left_d[v];
				taken_q[v] <= taken_d[v];
			end
		end else if (req_acc) begin
			// Requests alternate between the voices; a new request simply
			// overwrites a slot that has not been taken yet.
			if (last_went_second_q) begin
				pstep_q[0]  <= req_step;
				pcount_q[0] <= req_count;
				taken_q[0]  <= 1'b0;
			end else begin
				pstep_q[1]  <= req_step;
				pcount_q[1] <= req_count;
				taken_q[1]  <= 1'b0;
			end
			last_went_second_q <= !last_went_second_q;
		end
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1)  valid_s1    <= tick_acc;
			if (en_s2)  valid_s2    <= valid_s1;
			if (en_s3)  valid_s3    <= valid_s2;
			if (en_out) out_valid_q <= valid_s3;
		end
	end

	// Stage one holds the phase each voice had before the tick.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int v = 0; v < NUM_VOICES; v++) begin
				phase_s1[v]  <= phase_q[v];
				active_s1[v] <= active_d[v];
				busy_s1[v]   <= (left_d[v] != '0);
			end
		end
	end

	// Wave shapes from the phase read as a Q0.32 fraction. The sine folds the
	// top table bits to a quarter wave and looks up its magnitude.
	always_comb begin
		logic [31:0]              u;
		logic [31:0]              d;
		logic [SINE_TABLE_BITS-1:0] idx;
		logic [QW-1:0]            q;
		for (int v = 0; v < NUM_VOICES; v++) begin
			u   = 32'(phase_s1[v]) << (32 - PHASE_BITS);
			d   = u - 32'h4000_0000;
			idx = u[31 -: SINE_TABLE_BITS];
			q   = idx[QW-1:0];
			rom_addr[v] = idx[QW] ? (AW'(1 << QW) - {1'b0, q}) : {1'b0, q};
			neg_s1c[v]  = idx[QW+1];
			case (waveform_q)
				WAVE_SQUARE:   other_c[v] = u[31] ? 17'h1_8000 : 17'h0_8000;
				WAVE_SAW:      other_c[v] = {{2{~u[31]}}, u[30:16]};
				WAVE_TRIANGLE: begin
					case (u[31:30])
						2'b00:   other_c[v] = {2'b00, u[29:15]};
						2'b11:   other_c[v] = {2'b11, u[29:15]};
						// Falling half: one down to minus one.
						default: other_c[v] = 17'h0_8000 - {1'b0, d[30:15]};
					endcase
				end
				default:       other_c[v] = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int v = 0; v < NUM_VOICES; v++) begin
				mag_s2[v]    <= sine_rom[rom_addr[v]];
				neg_s2[v]    <= neg_s1c[v];
				other_s2[v]  <= other_c[v];
				active_s2[v] <= active_s1[v];
				busy_s2[v]   <= busy_s1[v];
			end
		end
	end

	// Stage three: select the wave and scale it by the amplitude. A voice
	// that was silent before the tick contributes nothing.
	always_comb begin
		logic [WAVE_W-1:0] wave;
		for (int v = 0; v < NUM_VOICES; v++) begin
			if (waveform_q == WAVE_SINE) begin
				wave = neg_s2[v] ? (WAVE_W'(0) - {1'b0, mag_s2[v]}) : {1'b0, mag_s2[v]};
			end else begin
				wave = other_s2[v];
			end
			prod_c[v] = PROD_W'($signed(wave)) * PROD_W'($signed({1'b0, amplitude_q}));
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int v = 0; v < NUM_VOICES; v++) begin
				prod_s3[v] <= active_s2[v] ? prod_c[v] : '0;
				busy_s3[v] <= busy_s2[v];
			end
		end
	end

	// Mix: each contribution is the product over 2^17 rounded half up, which
	// gives half the amplitude; the sum is saturated to the sample width.
	always_comb begin
		logic signed [PROD_W-1:0] rnd0;
		logic signed [PROD_W-1:0] rnd1;
		logic signed [MIX_W-1:0]  total;
		rnd0  = (prod_s3[0] + PROD_W'(65536)) >>> 17;
		rnd1  = (prod_s3[1] + PROD_W'(65536)) >>> 17;
		total = MIX_W'(rnd0) + MIX_W'(rnd1);
		if (total > MIX_W'(32767)) begin
			sample_c = 16'sh7FFF;
		end else if (total < -MIX_W'(32768)) begin
			sample_c = -16'sh8000;
		end else begin
			sample_c = SAMPLE_W'(total);
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			sample_q  <= sample_c;
			busy_q[0] <= busy_s3[0];
			busy_q[1] <= busy_s3[1];
		end
	end

	assign mix.valid          = out_valid_q;
	assign mix.sample         = sample_q;
	assign mix.voice_one_busy = busy_q[0];
	assign mix.voice_two_busy = busy_q[1];

endmodule
`default_nettype wire

### dv/dvtg_sample_checker.sv
// Checker of the tone generator: watches the channels, predicts each sample and compares it.
`timescale 1ns / 1ps
module dvtg_sample_checker import dvtg_pkg::*; (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             wr_en,
	input  wire             wr_index,
	input  wire [CFG_W-1:0] wr_data,
	dvtg_in_if              tone,
	dvtg_out_if             mix,
	output int              failures,
	output int              outstanding
);

	localparam int unsigned QUARTER = 1 << (SINE_TABLE_BITS_DEF - 2);

	typedef struct packed {
		logic [PHASE_BITS_DEF-1:0] phase;
		logic [PHASE_BITS_DEF-1:0] step;
		logic [COUNT_BITS_DEF-1:0] left;
		logic [PHASE_BITS_DEF-1:0] pending_step;
		logic [COUNT_BITS_DEF-1:0] pending_count;
		logic                      taken;
	} voice_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       one_busy;
		logic                       two_busy;
	} mix_beat_t;

	wave_t            shape;
	logic [AMP_W-1:0] gain;
	voice_t           voices [NUM_VOICES];
	logic             last_to_second;
	mix_beat_t        expected_samples [$];

	// Quarter-wave sine magnitude in Q15, Taylor series in Q30 with truncating products.
	function automatic int sine_q15(input int unsigned q);
		longint unsigned th;
		longint unsigned t;
		longint unsigned f;
		longint unsigned s;
		th = 64'(q);
		th = (th * HALF_PI_Q30) >> (SINE_TABLE_BITS_DEF - 2);
		t  = (th * th) >> 30;
		f  = Q30_ONE - t / 110;
		f  = Q30_ONE - ((t * f) >> 30) / 72;
		f  = Q30_ONE - ((t * f) >> 30) / 42;
		f  = Q30_ONE - ((t * f) >> 30) / 20;
		f  = Q30_ONE - ((t * f) >> 30) / 6;
		s  = (th * f) >> 30;
		return int'((s + 64'd16384) >> 15);
	endfunction

	// Wave level for a phase, 1.0 = 32768.
	function automatic int wave_level(input logic [PHASE_BITS_DEF-1:0] ph);
		logic [31:0]                    u;
		logic [SINE_TABLE_BITS_DEF-1:0] idx;
		int unsigned                    q;
		int                             m;
		u = 32'(ph) << (32 - PHASE_BITS_DEF);
		case (shape)
			WAVE_SQUARE: begin
				return u[31] ? -32768 : 32768;
			end
			WAVE_SINE: begin
				idx = u[31 -: SINE_TABLE_BITS_DEF];
				q   = 32'(idx[SINE_TABLE_BITS_DEF-3:0]);
				if (idx[SINE_TABLE_BITS_DEF-2])
					q = QUARTER - q;
				m = sine_q15(q);
				return idx[SINE_TABLE_BITS_DEF-1] ? -m : m;
			end
			WAVE_SAW: begin
				return -32768 + int'(u >> 16);
			end
			WAVE_TRIANGLE: begin
				if (u < 32'h4000_0000)
					return int'(u >> 15);
				if (u < 32'hC000_0000)
					return 32768 - int'((u - 32'h4000_0000) >> 15);
				return -32768 + int'((u - 32'hC000_0000) >> 15);
			end
			default: begin
				return 0;
			end
		endcase
	endfunction

	// One voice's share of the mix for this tick, then its accumulator and counter move on.
	function automatic longint advance_voice(input int vi);
		longint                  share;
		logic [PHASE_BITS_DEF:0] total;
		share = 0;
		if (voices[vi].left != 0) begin
			share = (longint'(wave_level(voices[vi].phase)) * longint'(gain) + 65536) >>> 17;
			total = {1'b0, voices[vi].phase} + {1'b0, voices[vi].step};
			voices[vi].phase = total[PHASE_BITS_DEF-1:0];
			if (total[PHASE_BITS_DEF]) begin
				voices[vi].left = voices[vi].left - 1'b1;
				if (!voices[vi].taken && voices[vi].left > 1)
					voices[vi].left = COUNT_BITS_DEF'(1);
			end
		end
		if (!voices[vi].taken && voices[vi].left == 0) begin
			voices[vi].step  = voices[vi].pending_step;
			voices[vi].left  = voices[vi].pending_count;
			voices[vi].taken = 1'b1;
		end
		return share;
	endfunction

	function automatic mix_beat_t predict_sample();
		longint    total;
		mix_beat_t beat;
		total = advance_voice(0);
		total += advance_voice(1);
		if (total > 32767)
			total = 32767;
		if (total < -32768)
			total = -32768;
		beat.sample   = total[SAMPLE_W-1:0];
		beat.one_busy = voices[0].left != 0;
		beat.two_busy = voices[1].left != 0;
		return beat;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mix_beat_t want;
		int        vi;
		if (!arst_n) begin
			shape = WAVE_SQUARE;
			gain  = '0;
			for (int i = 0; i < NUM_VOICES; i++)
				voices[i] = '0;
			last_to_second = 1'b1;
			expected_samples.delete();
		end else begin
			if (wr_en) begin
				case (cfg_reg_t'(wr_index))
					REG_WAVEFORM:  shape = wave_t'(wr_data[1:0]);
					REG_AMPLITUDE: gain  = wr_data[AMP_W-1:0];
					default: ;
				endcase
			end
			if (mix.valid && mix.ready) begin
				if (expected_samples.size() == 0) begin
					failures++;
					$error("unexpected sample transaction: sample %0d", mix.sample);
				end else begin
					want = expected_samples.pop_front();
					if (mix.sample !== want.sample) begin
						failures++;
						$error("sample: expected %0d, actual %0d", want.sample, mix.sample);
					end
					if (mix.voice_one_busy !== want.one_busy) begin
						failures++;
						$error("voice_one_busy: expected %0b, actual %0b", want.one_busy,
							mix.voice_one_busy);
					end
					if (mix.voice_two_busy !== want.two_busy) begin
						failures++;
						$error("voice_two_busy: expected %0b, actual %0b", want.two_busy,
							mix.voice_two_busy);
					end
				end
			end
			if (tone.valid && tone.ready) begin
				if (cmd_t'(tone.cmd) == CMD_REQUEST) begin
					// The step field is already Q0.24, the width of the phase accumulators.
					vi = last_to_second ? 0 : 1;
					voices[vi].pending_step  = PHASE_BITS_DEF'(tone.phase_step);
					voices[vi].pending_count = COUNT_BITS_DEF'(tone.tone_cycles);
					voices[vi].taken         = 1'b0;
					last_to_second           = !last_to_second;
				end else begin
					expected_samples.push_back(predict_sample());
				end
			end
		end
		outstanding = expected_samples.size();
	end

endmodule

### dv/tb_dual_voice_tone_generator.sv
// Testbench top of the tone generator: clock, reset, configuration, stimulus and verdict.
`timescale 1ns / 1ps
module tb_dual_voice_tone_generator;
	import dvtg_pkg::*;

	// A short directed run comes first, then eight phases of random
	// transactions, each under its own waveform and amplitude, and finally a
	// voice that is given a zero step. Registers are only written once every
	// sample of the previous phase has come back and the pipeline has settled.
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 130;
	localparam int HOLD_CYCLES     = 300;
	// Settling time after the last sample, which also covers trailing requests.
	localparam int SETTLE_CYCLES   = 8;

	typedef enum {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_pattern_t;

	logic             clk;
	logic             arst_n;
	logic             wr_en;
	logic             wr_index;
	logic [CFG_W-1:0] wr_data;

	dvtg_in_if  tone ();
	dvtg_out_if mix ();

	int failures;
	int outstanding;
	int burst_left;
	int holds_asked;
	int holds_done;

	dual_voice_tone_generator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.tone     (tone),
		.mix      (mix)
	);

	dvtg_sample_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.tone        (tone),
		.mix         (mix),
		.failures    (failures),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Writes both registers on consecutive cycles. The unused upper bits of
	// the waveform write carry noise, which the block must ignore.
	task automatic configure(input wave_t shape, input logic [AMP_W-1:0] gain);
		wr_en    <= 1'b1;
		wr_index <= REG_WAVEFORM;
		wr_data  <= {(CFG_W-2)'($urandom), shape};
		@(negedge clk);
		wr_index <= REG_AMPLITUDE;
		wr_data  <= gain;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// Offers one transaction on the tone channel and returns at the falling
	// edge after it was taken. Transactions go out in bursts of random length;
	// most bursts start after a short idle gap, some follow on directly.
	task automatic offer_tone(input cmd_t kind, input logic [STEP_W-1:0] step,
			input logic [WCOUNT_W-1:0] count);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				tone.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		tone.valid       <= 1'b1;
		tone.cmd         <= kind;
		tone.phase_step  <= step;
		tone.tone_cycles <= count;
		do
			@(posedge clk);
		while (!tone.ready);
		@(negedge clk);
	endtask

	// A tick carries random step and count fields, which the block must ignore.
	task automatic tick();
		offer_tone(CMD_TICK, STEP_W'($urandom), WCOUNT_W'($urandom));
	endtask

	task automatic request(input logic [STEP_W-1:0] step, input logic [WCOUNT_W-1:0] count);
		offer_tone(CMD_REQUEST, step, count);
	endtask

	// Mostly ticks. Requests use steps that wrap within a few ticks, so that
	// voices finish and reload often, and mostly short counts; now and then a
	// count over the whole field, which only a later request cuts short.
	task automatic random_item();
		logic [STEP_W-1:0]   step;
		logic [WCOUNT_W-1:0] count;
		int                  pick;
		if ($urandom_range(0, 99) >= 16) begin
			tick();
		end else begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				step = '1;
			else if (pick == 1)
				step = 24'h80_0000;
			else
				step = STEP_W'($urandom_range(1 << 20, (1 << 24) - 1));
			pick = $urandom_range(0, 9);
			if (pick < 7)
				count = WCOUNT_W'($urandom_range(0, 6));
			else if (pick < 9)
				count = WCOUNT_W'($urandom_range(7, 40));
			else
				count = WCOUNT_W'($urandom);
			request(step, count);
		end
	endtask

	// Waits until every predicted sample has been seen, then lets the
	// pipeline run dry so that the next register write finds the block idle.
	task automatic drain_samples();
		tone.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Receiver: switches between randomly chosen stall patterns. When the
	// stimulus asks for it, it holds off completely, long enough that the
	// pipeline fills and the block stops taking transactions.
	initial begin
		rx_pattern_t pattern;
		int          cycle;
		mix.ready = 1'b0;
		pattern   = RX_FREE;
		cycle     = 0;
		forever begin
			@(negedge clk);
			if (holds_done < holds_asked) begin
				holds_done++;
				mix.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				if (cycle % 48 == 0)
					pattern = rx_pattern_t'($urandom_range(0, 3));
				cycle++;
				case (pattern)
					RX_FREE:   mix.ready <= 1'b1;
					RX_MOSTLY: mix.ready <= ($urandom_range(0, 3) != 0);
					RX_SPARSE: mix.ready <= ($urandom_range(0, 3) == 0);
					default:   mix.ready <= (cycle % 2 == 0);
				endcase
			end
		end
	end

	initial begin
		wave_t sweep [4];
		sweep = '{WAVE_SQUARE, WAVE_SINE, WAVE_SAW, WAVE_TRIANGLE};

		arst_n           = 1'b0;
		wr_en            = 1'b0;
		wr_index         = REG_WAVEFORM;
		wr_data          = '0;
		tone.valid       = 1'b0;
		tone.cmd         = CMD_TICK;
		tone.phase_step  = '0;
		tone.tone_cycles = '0;
		burst_left       = 0;
		holds_asked      = 0;
		holds_done       = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, square wave at full amplitude so that two voices in
		// phase drive the mix into saturation.
		configure(WAVE_SQUARE, '1);
		tick();                                  // nothing loaded yet: silence
		request(24'hFF_FFFF, WCOUNT_W'(2));      // voice one, largest step
		request(24'h80_0000, 24'hFF_FFFF);       // voice two, largest count
		repeat (4) tick();
		request(24'h40_0000, '0);                // voice one: already done, loads idle
		request(24'hC0_0000, WCOUNT_W'(1));      // voice two: the long tone is cut to one
		repeat (6) tick();
		// Two requests per voice in a row: the second overwrites an untaken slot.
		request(24'h55_5555, WCOUNT_W'(3));
		request(24'hAA_AAAA, WCOUNT_W'(3));
		request(24'h12_3456, WCOUNT_W'(5));
		request(24'hED_CBA9, WCOUNT_W'(1));
		repeat (6) tick();
		drain_samples();

		// Random phases: every waveform at full scale, then zero and random
		// amplitudes. Two of them begin with a long stall of the receiver.
		for (int p = 0; p < PHASES; p++) begin
			wave_t            shape;
			logic [AMP_W-1:0] gain;
			if (p < 4)
				shape = sweep[p];
			else
				shape = sweep[$urandom_range(0, 3)];
			case (p)
				0, 1, 2, 3: gain = '1;
				4:          gain = '0;
				default:    gain = AMP_W'($urandom);
			endcase
			configure(shape, gain);
			if (p == 1 || p == 5)
				holds_asked++;
			repeat (ITEMS_PER_PHASE) random_item();
			drain_samples();
		end

		// A zero step never wraps, so that voice keeps its level for good; it
		// therefore comes last. The other voice gets a zero count and stays quiet.
		configure(WAVE_TRIANGLE, '1);
		request('0, WCOUNT_W'(3));
		request('0, '0);
		repeat (16) tick();
		drain_samples();

		if (failures == 0) begin
			$display("dual_voice_tone_generator verification clean");
		end else begin
			$display("dual_voice_tone_generator verification failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("dual_voice_tone_generator verification failed");
		$finish;
	end

endmodule
